@@ hdl/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;

	// action codes
	localparam logic [2:0] ACT_INIT   = 3'd0;
	localparam logic [2:0] ACT_ALLOC  = 3'd1;
	localparam logic [2:0] ACT_FREE   = 3'd2;
	localparam logic [2:0] ACT_RESIZE = 3'd3;
	localparam logic [2:0] ACT_QUERY  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;
	localparam logic [1:0] ST_NOGROW  = 2'd3;

	// unit arithmetic width, smallest block and smallest heap in units
	localparam int UNW       = 15;
	localparam int MIN_UNITS = 2;
	localparam int MIN_HEAP  = 8;

	// register index of heap_bytes
	localparam logic REG_HEAP_BYTES = 1'b0;

endpackage
`default_nettype wire

@@ hdl/first_fit_heap_allocator_unit.sv @@
// channel | dir | beat fields (low bit first)
// s_*     | in  | tuser: action[2:0]; tdata: req_bytes[15:0] block_addr[31:16] from_top[32]
// m_*     | out | tdata: result_addr[15:0] status[17:16] free_bytes[34:18]
//         |     |        largest_free[51:35] used_bytes[68:52]
// apb     | in  | heap_bytes at byte address 0
//
// one request at a time through a small sequencer around a header store with one read port;
// the work per request grows with the free-list nodes visited by the search or insert walk,
// the heap blocks stepped over by the address check and the free blocks in the closing
// largest-block scan, on top of the update, accept, scan start, scan end and output states;
// the store read port sets the pace.
// reset clears list pointers and counters at once; the header store needs no clearing.
// a result waiting on m_tready holds the next request in the sequencer's last state.
`default_nettype none
module first_fit_heap_allocator_unit #(
	parameter int HEAP_UNITS = 8192
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // req_bytes, block_addr, from_top
	input  wire  [2:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // result_addr, status, free_bytes, largest_free, used_bytes
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int MAX_UNITS = (HEAP_UNITS > 8192) ? 8192 : HEAP_UNITS;
	localparam int IW = $clog2(MAX_UNITS);
	localparam int SW = $clog2(MAX_UNITS + 1);
	localparam int LW = IW + 1;
	localparam int UNW = ffha_pkg::UNW;
	localparam logic [LW-1:0] NIL = {LW{1'b1}};

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_R_DEC, S_R_SHR,
		S_G_RD, S_G_CHK, S_M_GO, S_M_RD, S_M_CHK, S_M_W1, S_M_W2,
		S_X1, S_X2, S_U1, S_T1, S_T2, S_W_GO, S_W_RD, S_W_CHK, S_DONE
	} state_t;

	state_t state_q;

	// header store, one field per array
	logic [SW-1:0] size_mem [MAX_UNITS];
	logic          used_mem [MAX_UNITS];
	logic [LW-1:0] prev_mem [MAX_UNITS];
	logic [LW-1:0] next_mem [MAX_UNITS];

	logic [IW-1:0] ra;
	logic [SW-1:0] rd_size;
	logic          rd_used;
	logic [LW-1:0] rd_prev, rd_next;

	logic          sz_we, us_we, pv_we, nx_we, us_wd;
	logic [IW-1:0] sz_wa, us_wa, pv_wa, nx_wa;
	logic [SW-1:0] sz_wd;
	logic [LW-1:0] pv_wd, nx_wd;

	logic [16:0]   heap_bytes_q;
	logic [LW-1:0] first_q, last_q, cur_q, pred_q, n_q, nnext_q, lp_q, ln_q;
	logic [SW-1:0] free_q, active_q, largest_q, bsz_q, psize_q, nsize_q;
	logic [SW-1:0] osz_q, ksz_q, take_q;
	logic [IW-1:0] b_q, o_q, k_q;
	logic [2:0]    act_q;
	logic          top_q;
	logic [UNW-1:0] need_q, u_q;
	logic [12:0]   s_q;
	logic [15:0]   addr_q, res_q;
	logic [1:0]    status_q;
	logic          m_tvalid_q;
	logic [71:0]   m_tdata_q;

	// request decode
	logic [15:0]    in_req, in_addr;
	logic [16:0]    req_rnd;
	logic [UNW-1:0] in_need;
	logic           addr_bad;
	logic [13:0]    init_hu;
	logic [SW-1:0]  init_units;

	assign in_req  = s_tdata[15:0];
	assign in_addr = s_tdata[31:16];
	assign req_rnd = {1'b0, in_req} + 17'd15;
	assign in_need = (req_rnd[16:3] < 14'(ffha_pkg::MIN_UNITS)) ?
		UNW'(ffha_pkg::MIN_UNITS) : UNW'(req_rnd[16:3]);
	assign addr_bad = (active_q == '0) || (in_addr < 16'd8) || (in_addr[2:0] != 3'd0);
	assign init_hu = heap_bytes_q[16:3];

	always_comb begin
		if (UNW'(init_hu) > UNW'(MAX_UNITS)) begin
			init_units = SW'(MAX_UNITS);
		end else if (init_hu < 14'(ffha_pkg::MIN_HEAP)) begin
			init_units = SW'(ffha_pkg::MIN_HEAP);
		end else begin
			init_units = SW'(init_hu);
		end
	end

	// read data widened for the shared compare
	logic [UNW-1:0] rsize, cur_u, bsz_u, b_u;
	assign rsize = UNW'(rd_size);
	assign cur_u = UNW'(cur_q[IW-1:0]);
	assign bsz_u = UNW'(bsz_q);
	assign b_u   = UNW'(b_q);

	// coalescing decisions for the insert
	logic           mp, mn;
	logic [IW-1:0]  tb;
	logic [UNW-1:0] tsize;
	logic [LW-1:0]  tnext;
	assign mp = !pred_q[LW-1] &&
		(UNW'(pred_q[IW-1:0]) + UNW'(psize_q) == b_u);
	assign mn = !n_q[LW-1] && (b_u + bsz_u == UNW'(n_q[IW-1:0]));
	assign tb = mp ? pred_q[IW-1:0] : b_q;
	assign tsize = (mp ? UNW'(psize_q) : '0) + bsz_u + (mn ? UNW'(nsize_q) : '0);
	assign tnext = mn ? nnext_q : n_q;

	// grow target and shortfall
	logic [UNW-1:0] grow_s, extra;
	assign grow_s = b_u + bsz_u;
	assign extra  = need_q - bsz_u;

	// read address
	always_comb begin
		case (state_q)
			S_F_RD:  ra = u_q[IW-1:0];
			default: ra = cur_q[IW-1:0];
		endcase
	end

	// store write ports
	always_comb begin
		sz_we = 1'b0; sz_wa = o_q; sz_wd = osz_q;
		us_we = 1'b0; us_wa = o_q; us_wd = 1'b1;
		pv_we = 1'b0; pv_wa = k_q; pv_wd = lp_q;
		nx_we = 1'b0; nx_wa = k_q; nx_wd = ln_q;
		case (state_q)
			S_INIT: begin
				sz_we = 1'b1; sz_wa = '0; sz_wd = init_units;
				us_we = 1'b1; us_wa = '0; us_wd = 1'b0;
				pv_we = 1'b1; pv_wa = '0; pv_wd = NIL;
				nx_we = 1'b1; nx_wa = '0; nx_wd = NIL;
			end
			S_X1: begin
				sz_we = 1'b1;
				us_we = 1'b1;
				pv_we = 1'b1;
				nx_we = 1'b1;
			end
			S_X2: begin
				sz_we = 1'b1; sz_wa = k_q; sz_wd = ksz_q;
				us_we = 1'b1; us_wa = k_q; us_wd = 1'b0;
				nx_we = !lp_q[LW-1]; nx_wa = lp_q[IW-1:0]; nx_wd = {1'b0, k_q};
				pv_we = !ln_q[LW-1]; pv_wa = ln_q[IW-1:0]; pv_wd = {1'b0, k_q};
			end
			S_U1: begin
				sz_we = 1'b1;
				us_we = 1'b1;
				nx_we = !lp_q[LW-1]; nx_wa = lp_q[IW-1:0]; nx_wd = ln_q;
				pv_we = !ln_q[LW-1]; pv_wa = ln_q[IW-1:0]; pv_wd = lp_q;
			end
			S_T1, S_R_SHR: begin
				sz_we = 1'b1;
			end
			S_T2: begin
				sz_we = 1'b1; sz_wa = k_q; sz_wd = ksz_q;
				us_we = 1'b1; us_wa = k_q;
			end
			S_M_W1: begin
				sz_we = 1'b1; sz_wa = tb; sz_wd = SW'(tsize);
				us_we = 1'b1; us_wa = tb; us_wd = 1'b0;
				nx_we = 1'b1; nx_wa = tb; nx_wd = tnext;
				pv_we = !mp; pv_wa = tb; pv_wd = pred_q;
			end
			S_M_W2: begin
				nx_we = !mp && !pred_q[LW-1]; nx_wa = pred_q[IW-1:0]; nx_wd = {1'b0, b_q};
				pv_we = !tnext[LW-1]; pv_wa = tnext[IW-1:0]; pv_wd = {1'b0, tb};
			end
			default: begin
				sz_we = 1'b0;
			end
		endcase
	end

	// header store arrays
	always_ff @(posedge clk) begin
		rd_size <= size_mem[ra];
		rd_used <= used_mem[ra];
		rd_prev <= prev_mem[ra];
		rd_next <= next_mem[ra];
		if (sz_we) begin
			size_mem[sz_wa] <= sz_wd;
		end
		if (us_we) begin
			used_mem[us_wa] <= us_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
	end

	// configuration port
	assign pready = 1'b1;
	always_comb begin
		if (paddr == 3'd0) begin
			prdata = 32'(heap_bytes_q);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_bytes_q <= 17'd65536;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == ffha_pkg::REG_HEAP_BYTES && paddr[1:0] == 2'd0) begin
			heap_bytes_q <= pwdata[16:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			first_q    <= NIL;
			last_q     <= NIL;
			free_q     <= '0;
			active_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q    <= s_tuser;
						top_q    <= s_tdata[32];
						addr_q   <= in_addr;
						need_q   <= in_need;
						s_q      <= in_addr[15:3] - 13'd1;
						u_q      <= '0;
						status_q <= ffha_pkg::ST_OK;
						res_q    <= '0;
						case (s_tuser)
							ffha_pkg::ACT_INIT: begin
								state_q <= S_INIT;
							end
							ffha_pkg::ACT_ALLOC: begin
								cur_q   <= s_tdata[32] ? last_q : first_q;
								state_q <= S_A_RD;
							end
							ffha_pkg::ACT_FREE, ffha_pkg::ACT_RESIZE: begin
								if (s_tuser == ffha_pkg::ACT_FREE && in_addr == '0) begin
									state_q <= S_W_GO;
								end else if (addr_bad) begin
									status_q <= ffha_pkg::ST_BADADDR;
									state_q  <= S_W_GO;
								end else begin
									state_q <= S_F_RD;
								end
							end
							default: begin
								state_q <= S_W_GO;
							end
						endcase
					end
				end
				S_INIT: begin
					first_q  <= '0;
					last_q   <= '0;
					free_q   <= init_units;
					active_q <= init_units;
					state_q  <= S_W_GO;
				end
				// first-fit search, one node per read
				S_A_RD: begin
					if (cur_q[LW-1]) begin
						status_q <= ffha_pkg::ST_NOSPACE;
						state_q  <= S_W_GO;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				S_A_CHK: begin
					if (rsize >= need_q) begin
						lp_q <= rd_prev;
						ln_q <= rd_next;
						o_q  <= cur_q[IW-1:0];
						if (rsize >= need_q + UNW'(ffha_pkg::MIN_UNITS)) begin
							take_q <= SW'(need_q);
							if (top_q) begin
								osz_q   <= SW'(rsize - need_q);
								k_q     <= IW'(cur_u + rsize - need_q);
								ksz_q   <= SW'(need_q);
								res_q   <= 16'({UNW'(cur_u + rsize - need_q + 15'd1), 3'b000});
								state_q <= S_T1;
							end else begin
								osz_q   <= SW'(need_q);
								k_q     <= IW'(cur_u + need_q);
								ksz_q   <= SW'(rsize - need_q);
								res_q   <= 16'({UNW'(cur_u + 15'd1), 3'b000});
								state_q <= S_X1;
							end
						end else begin
							osz_q   <= rd_size;
							take_q  <= rd_size;
							res_q   <= 16'({UNW'(cur_u + 15'd1), 3'b000});
							state_q <= S_U1;
						end
					end else begin
						cur_q   <= top_q ? rd_prev : rd_next;
						state_q <= S_A_RD;
					end
				end
				// address check, stepping block by block from the heap start
				S_F_RD: begin
					if (u_q >= UNW'(active_q)) begin
						status_q <= ffha_pkg::ST_BADADDR;
						state_q  <= S_W_GO;
					end else begin
						state_q <= S_F_CHK;
					end
				end
				S_F_CHK: begin
					if (u_q == UNW'(s_q)) begin
						b_q   <= u_q[IW-1:0];
						bsz_q <= rd_size;
						if (!rd_used) begin
							status_q <= ffha_pkg::ST_BADADDR;
							state_q  <= S_W_GO;
						end else if (act_q == ffha_pkg::ACT_FREE) begin
							state_q <= S_M_GO;
						end else begin
							state_q <= S_R_DEC;
						end
					end else if (u_q > UNW'(s_q) || rd_size == '0) begin
						status_q <= ffha_pkg::ST_BADADDR;
						state_q  <= S_W_GO;
					end else begin
						u_q     <= u_q + rsize;
						state_q <= S_F_RD;
					end
				end
				// resize decision
				S_R_DEC: begin
					res_q <= addr_q;
					o_q   <= b_q;
					if (need_q < bsz_u) begin
						if (bsz_u - need_q >= UNW'(ffha_pkg::MIN_UNITS)) begin
							osz_q   <= SW'(need_q);
							b_q     <= IW'(b_u + need_q);
							bsz_q   <= SW'(bsz_u - need_q);
							state_q <= S_R_SHR;
						end else begin
							state_q <= S_W_GO;
						end
					end else if (need_q == bsz_u) begin
						state_q <= S_W_GO;
					end else if (grow_s >= UNW'(active_q)) begin
						res_q    <= '0;
						status_q <= ffha_pkg::ST_NOGROW;
						state_q  <= S_W_GO;
					end else begin
						cur_q   <= {1'b0, grow_s[IW-1:0]};
						state_q <= S_G_RD;
					end
				end
				S_R_SHR: begin
					state_q <= S_M_GO;
				end
				S_G_RD: begin
					state_q <= S_G_CHK;
				end
				S_G_CHK: begin
					if (rd_used || rsize < extra) begin
						res_q    <= '0;
						status_q <= ffha_pkg::ST_NOGROW;
						state_q  <= S_W_GO;
					end else begin
						lp_q <= rd_prev;
						ln_q <= rd_next;
						if (rsize >= extra + UNW'(ffha_pkg::MIN_UNITS)) begin
							osz_q   <= SW'(need_q);
							k_q     <= IW'(cur_u + extra);
							ksz_q   <= SW'(rsize - extra);
							take_q  <= SW'(extra);
							state_q <= S_X1;
						end else begin
							osz_q   <= SW'(bsz_u + rsize);
							take_q  <= rd_size;
							state_q <= S_U1;
						end
					end
				end
				// address-ordered insert walk
				S_M_GO: begin
					cur_q   <= first_q;
					pred_q  <= NIL;
					state_q <= S_M_RD;
				end
				S_M_RD: begin
					if (cur_q[LW-1]) begin
						n_q     <= NIL;
						state_q <= S_M_W1;
					end else begin
						state_q <= S_M_CHK;
					end
				end
				S_M_CHK: begin
					if (cur_u >= b_u) begin
						n_q     <= cur_q;
						nsize_q <= rd_size;
						nnext_q <= rd_next;
						state_q <= S_M_W1;
					end else begin
						pred_q  <= cur_q;
						psize_q <= rd_size;
						cur_q   <= rd_next;
						state_q <= S_M_RD;
					end
				end
				S_M_W1: begin
					state_q <= S_M_W2;
				end
				S_M_W2: begin
					if (!mp && pred_q[LW-1]) begin
						first_q <= {1'b0, b_q};
					end
					if (tnext[LW-1]) begin
						last_q <= {1'b0, tb};
					end
					free_q  <= free_q + bsz_q;
					state_q <= S_W_GO;
				end
				// take a node out of the list, hand its place to the remainder, or shrink it in place
				S_X1: begin
					state_q <= S_X2;
				end
				S_X2: begin
					if (lp_q[LW-1]) begin
						first_q <= {1'b0, k_q};
					end
					if (ln_q[LW-1]) begin
						last_q <= {1'b0, k_q};
					end
					free_q  <= free_q - take_q;
					state_q <= S_W_GO;
				end
				S_U1: begin
					if (lp_q[LW-1]) begin
						first_q <= ln_q;
					end
					if (ln_q[LW-1]) begin
						last_q <= lp_q;
					end
					free_q  <= free_q - take_q;
					state_q <= S_W_GO;
				end
				S_T1: begin
					state_q <= S_T2;
				end
				S_T2: begin
					free_q  <= free_q - take_q;
					state_q <= S_W_GO;
				end
				// largest free block scan
				S_W_GO: begin
					cur_q     <= first_q;
					largest_q <= '0;
					state_q   <= S_W_RD;
				end
				S_W_RD: begin
					state_q <= cur_q[LW-1] ? S_DONE : S_W_CHK;
				end
				S_W_CHK: begin
					if (rd_size > largest_q) begin
						largest_q <= rd_size;
					end
					cur_q   <= rd_next;
					state_q <= S_W_RD;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'd0,
							17'({SW'(active_q - free_q), 3'b000}),
							17'({largest_q, 3'b000}),
							17'({free_q, 3'b000}),
							status_q, res_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	// list ends are empty together
	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		first_q[LW-1] == last_q[LW-1]) else $error("free list ends disagree");
	// free space never exceeds the heap
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= active_q) else $error("free count above heap size");
	// a taken request leaves the idle state
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("sequencer did not start");
	// a returned offset goes with status ok
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:0] != 16'd0 |-> m_tdata[17:16] == ffha_pkg::ST_OK)
		else $error("offset returned on failure");
`endif

endmodule
`default_nettype wire
